[hdl/lsogi_pkg.sv]
// ----------------------------------------------------------------------------
// lsogi_pkg: shared constants and types for the obstacle grid block.
// Grid geometry, request codes, register indexes and the packed request, response and configuration structs.
// ----------------------------------------------------------------------------
`default_nettype none
package lsogi_pkg;
	localparam int GRID_DIM    = 512;
	localparam int GRID_W      = $clog2(GRID_DIM);
	localparam int GRID_CELLS  = GRID_DIM * GRID_DIM;
	localparam int ADDR_W      = 2 * GRID_W;
	localparam int MAX_SAMPLES = 4096;
	localparam int CNT_W       = $clog2(MAX_SAMPLES);
	localparam int MAX_INFLATE = 8;
	localparam int K_W         = 6;

	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_SAMPLE = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;

	localparam logic [2:0] REG_RANGE_MIN  = 3'd0;
	localparam logic [2:0] REG_RANGE_MAX  = 3'd1;
	localparam logic [2:0] REG_ANGLE_START = 3'd2;
	localparam logic [2:0] REG_ANGLE_STEP = 3'd3;
	localparam logic [2:0] REG_CELL_SIZE  = 3'd4;
	localparam logic [2:0] REG_ORIGIN_X   = 3'd5;
	localparam logic [2:0] REG_ORIGIN_Y   = 3'd6;
	localparam logic [2:0] REG_INFL_RAD   = 3'd7;

	localparam logic [6:0] COST_OCC = 7'd100;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] range_mm;
		logic [8:0]  read_x;
		logic [8:0]  read_y;
	} req_t;

	typedef struct packed {
		logic [6:0] cell_cost;
		logic       occupied;
	} rsp_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [15:0] data;
	} cfg_t;
endpackage
`default_nettype wire

[hdl/lsogi_if.sv]
// ----------------------------------------------------------------------------
// lsogi_if: valid/ready channel carrying one payload.
// Used for requests, responses and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface lsogi_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hdl/lsogi_div.sv]
// ----------------------------------------------------------------------------
// lsogi_div: restoring signed divider, one quotient bit per cycle.
// Quotient truncates toward zero, as a C integer division does.
// ----------------------------------------------------------------------------
`default_nettype none
module lsogi_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [47:0] num,
	input  wire logic        [25:0] den,
	output logic                    done,
	output logic signed [47:0]      quo
);
	logic [47:0] mag_q;
	logic [47:0] rem_q;
	logic [25:0] den_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [48:0] trial;

	assign trial = {rem_q, mag_q[47]} - {23'd0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd48;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num[47] ? 48'(-num) : num;
			neg_q <= num[47];
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[48]) begin
				rem_q <= trial[47:0];
				mag_q <= {mag_q[46:0], 1'b1};
			end else begin
				rem_q <= {rem_q[46:0], mag_q[47]};
				mag_q <= {mag_q[46:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? -$signed(mag_q) : $signed(mag_q);
endmodule
`default_nettype wire

[hdl/lidar_scan_obstacle_grid_inflate.sv]
// ----------------------------------------------------------------------------
// lidar_scan_obstacle_grid_inflate: lidar samples to an inflated obstacle grid.
// Sequencer with one shared multiplier and one serial divider.
// ----------------------------------------------------------------------------
// A clear request sweeps the 512x512 one-bit grid one cell a cycle; a
// clearing pass also runs after reset before the first request is taken.
// A read passes through S_RD and S_RD2. Its response sits in an output
// register, and while an earlier response is still waiting, a read holds
// in S_RD2, and no other request is taken until it moves on. A sample
// whose range is out of bounds returns to idle from S_ANG. Any other
// sample evaluates the two sines (six steps each on the shared 32x32
// multiplier) and then runs the two serial divisions for the cell
// coordinates; a hit off the grid ends there. A hit on the grid adds a
// third division for the inflation half width k, the states S_SQ and
// S_SQ2 for the squared radius and cell size, and the states S_WIN,
// S_WMUL and S_WCMP for each offset of the (2k+1)^2 window, each of which
// may write one grid bit; k is clamped at its limit of 8. Configuration
// writes are always accepted.
`default_nettype none
module lidar_scan_obstacle_grid_inflate (
	input  wire logic clk,
	input  wire logic arst_n,
	lsogi_if.sink     req,
	lsogi_if.source   rsp,
	lsogi_if.sink     cfg
);
	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_ANG   = 5'd2;
	localparam logic [4:0] S_TRIG  = 5'd3;
	localparam logic [4:0] S_PX    = 5'd4;
	localparam logic [4:0] S_DX    = 5'd5;
	localparam logic [4:0] S_PY    = 5'd6;
	localparam logic [4:0] S_DY    = 5'd7;
	localparam logic [4:0] S_CHK   = 5'd8;
	localparam logic [4:0] S_DK    = 5'd9;
	localparam logic [4:0] S_SQ    = 5'd10;
	localparam logic [4:0] S_SQ2   = 5'd11;
	localparam logic [4:0] S_WIN   = 5'd12;
	localparam logic [4:0] S_WMUL  = 5'd13;
	localparam logic [4:0] S_WCMP  = 5'd14;
	localparam logic [4:0] S_RD    = 5'd15;
	localparam logic [4:0] S_RD2   = 5'd16;
	localparam logic [4:0] S_WAIT  = 5'd17;

	localparam int GW = lsogi_pkg::GRID_W;
	localparam int AW = lsogi_pkg::ADDR_W;
	localparam int K_W = lsogi_pkg::K_W;
	typedef lsogi_pkg::rsp_t rsp_t_local;

	logic [15:0] rmin_q, rmax_q, astart_q, astep_q;
	logic [9:0]  cell_q, rad_q;
	logic signed [15:0] ox_q, oy_q;

	logic [4:0]  state_q;
	logic [lsogi_pkg::CNT_W-1:0] cnt_q;
	logic [AW-1:0] clr_q;
	logic [15:0] range_q;
	logic [15:0] ang_q;
	logic [2:0]  tstep_q;
	logic        tsel_q;
	logic [14:0] t_q;
	logic [31:0] z2_q, p_q;
	logic signed [16:0] cos_q, sin_q;
	logic signed [47:0] cx_q, cy_q;
	logic [K_W-1:0] k_q;
	logic [19:0] lim_q, c2_q;
	logic signed [K_W:0] dx_q, dy_q;
	logic [7:0]  d2_q;
	logic [AW-1:0] rd_addr_q;
	logic        rd_q;
	rsp_t_local  rsp_q;
	logic        rsp_v_q;

	// Grid memory.
	logic mem [lsogi_pkg::GRID_CELLS];
	logic          we;
	logic [AW-1:0] waddr;
	logic          wdata;
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[rd_addr_q];
	end

	// Shared multiplier.
	logic [31:0] ma, mb;
	logic [63:0] mp;
	assign mp = ma * mb;

	// Shared divider.
	logic               dstart, ddone;
	logic signed [47:0] dnum, dquo;
	logic [25:0]        dden;
	lsogi_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum), .den(dden),
		.done(ddone), .quo(dquo)
	);

	logic [9:0] cellv;
	assign cellv = (cell_q == 10'd0) ? 10'd1 : cell_q;

	// Quadrant handling for the trig angle being evaluated.
	logic [15:0] ta;
	logic [14:0] tq;
	assign ta = tsel_q ? ang_q : 16'(ang_q + 16'd16384);
	assign tq = ta[14] ? 15'(15'd16384 - {1'b0, ta[13:0]}) : {1'b0, ta[13:0]};

	logic [31:0] sv;
	logic signed [16:0] sres;
	assign sv = (p_q << 1) > 32'd32767 ? 32'd32767 : (p_q << 1);
	assign sres = ta[15] ? -$signed({2'b0, sv[14:0]}) : $signed({2'b0, sv[14:0]});

	logic signed [GW+K_W+1:0] nx, ny;
	logic signed [47:0] sprod;
	logic signed [16:0] trig_sel;
	logic signed [16:0] rng_s;
	assign trig_sel = (state_q == S_PX) ? cos_q : sin_q;
	assign rng_s = $signed({1'b0, range_q});
	assign sprod = 48'(rng_s) * 48'(trig_sel);

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (tstep_q)
			3'd0: begin ma = {17'd0, tq}; mb = {17'd0, tq}; end
			3'd1: begin ma = z2_q; mb = 32'd77; end
			3'd2: begin ma = z2_q; mb = p_q; end
			3'd3: begin ma = z2_q; mb = p_q; end
			3'd4: begin ma = {17'd0, tq}; mb = p_q; end
			default: begin ma = '0; mb = '0; end
		endcase
		if (state_q == S_SQ) begin
			ma = {22'd0, rad_q}; mb = {22'd0, rad_q};
		end else if (state_q == S_SQ2) begin
			ma = {22'd0, cellv}; mb = {22'd0, cellv};
		end else if (state_q == S_WMUL) begin
			ma = {24'd0, d2_q}; mb = {12'd0, c2_q};
		end
	end

	assign nx = (GW+K_W+2)'(cx_q) + (GW+K_W+2)'(dx_q);
	assign ny = (GW+K_W+2)'(cy_q) + (GW+K_W+2)'(dy_q);

	logic [31:0] wprod_q;
	logic in_grid;
	assign in_grid = nx >= 0 && nx < lsogi_pkg::GRID_DIM &&
		ny >= 0 && ny < lsogi_pkg::GRID_DIM;

	always_comb begin
		we = 1'b0;
		waddr = clr_q;
		wdata = 1'b0;
		dstart = 1'b0;
		dnum = '0;
		dden = '0;
		if (state_q == S_CLR) begin
			we = 1'b1;
		end else if (state_q == S_WCMP && in_grid && {12'd0, wprod_q} <= {24'd0, lim_q}) begin
			we = 1'b1;
			wdata = 1'b1;
			waddr = {ny[GW-1:0], nx[GW-1:0]};
		end
		if (state_q == S_PX || state_q == S_PY) begin
			dstart = 1'b1;
			dnum = sprod - 48'(((state_q == S_PX) ? ox_q : oy_q) * 32'sd32768);
			dden = {1'b0, cellv, 15'd0};
		end else if (state_q == S_CHK) begin
			dstart = 1'b1;
			dnum = {38'd0, rad_q};
			dden = {16'd0, cellv};
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_v_q;
	assign rsp.payload = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmin_q   <= 16'd0;
			rmax_q   <= 16'd65535;
			astart_q <= 16'd0;
			astep_q  <= 16'd182;
			cell_q   <= 10'd50;
			ox_q     <= -16'sd12500;
			oy_q     <= -16'sd12500;
			rad_q    <= 10'd200;
		end else if (cfg.valid) begin
			unique case (cfg.payload.index)
				lsogi_pkg::REG_RANGE_MIN:   rmin_q   <= cfg.payload.data;
				lsogi_pkg::REG_RANGE_MAX:   rmax_q   <= cfg.payload.data;
				lsogi_pkg::REG_ANGLE_START: astart_q <= cfg.payload.data;
				lsogi_pkg::REG_ANGLE_STEP:  astep_q  <= cfg.payload.data;
				lsogi_pkg::REG_CELL_SIZE:   cell_q   <= cfg.payload.data[9:0];
				lsogi_pkg::REG_ORIGIN_X:    ox_q     <= cfg.payload.data;
				lsogi_pkg::REG_ORIGIN_Y:    oy_q     <= cfg.payload.data;
				lsogi_pkg::REG_INFL_RAD:    rad_q    <= cfg.payload.data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			cnt_q   <= '0;
			rsp_v_q <= 1'b0;
			tstep_q <= 3'd0;
			tsel_q  <= 1'b0;
		end else begin
			// A read loads the output register once the previous response is gone.
			if (state_q == S_RD2 && (!rsp_v_q || rsp.ready))
				rsp_v_q <= 1'b1;
			else if (rsp.ready)
				rsp_v_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req.valid && req.ready) begin
						range_q   <= req.payload.range_mm;
						rd_addr_q <= {req.payload.read_y, req.payload.read_x};
						case (req.payload.req_type)
							lsogi_pkg::REQ_CLEAR: begin
								cnt_q <= '0;
								clr_q <= '0;
								state_q <= S_CLR;
							end
							lsogi_pkg::REQ_SAMPLE: state_q <= S_ANG;
							lsogi_pkg::REQ_READ:   state_q <= S_RD;
							default: ;
						endcase
					end
				end
				S_ANG: begin
					ang_q <= 16'(astart_q + 16'(32'(cnt_q) * 32'(astep_q)));
					cnt_q <= cnt_q + 1'b1;
					if (range_q > rmin_q && range_q < rmax_q) begin
						state_q <= S_TRIG;
						tstep_q <= 3'd0;
						tsel_q  <= 1'b0;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_TRIG: begin
					tstep_q <= tstep_q + 3'd1;
					unique case (tstep_q)
						3'd0: z2_q <= 32'(mp >> 14);
						3'd1: p_q <= 32'd1306 - 32'(mp >> 14);
						3'd2: p_q <= 32'd10583 - 32'(mp >> 14);
						3'd3: p_q <= 32'd25736 - 32'(mp >> 14);
						3'd4: p_q <= 32'(mp >> 14);
						default: begin
							tstep_q <= 3'd0;
							if (tsel_q) begin
								sin_q <= sres;
								state_q <= S_PX;
							end else begin
								cos_q <= sres;
								tsel_q <= 1'b1;
							end
						end
					endcase
				end
				S_PX: state_q <= S_DX;
				S_DX: if (ddone) begin
					cx_q <= dquo;
					state_q <= S_PY;
				end
				S_PY: state_q <= S_DY;
				S_DY: if (ddone) begin
					cy_q <= dquo;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (cx_q >= 0 && cx_q < lsogi_pkg::GRID_DIM &&
					    cy_q >= 0 && cy_q < lsogi_pkg::GRID_DIM)
						state_q <= S_DK;
					else
						state_q <= S_IDLE;
				end
				S_DK: if (ddone) begin
					k_q <= (dquo > lsogi_pkg::MAX_INFLATE) ?
						K_W'(lsogi_pkg::MAX_INFLATE) : K_W'(dquo);
					state_q <= S_SQ;
				end
				S_SQ: begin
					lim_q <= mp[19:0];
					state_q <= S_SQ2;
				end
				S_SQ2: begin
					c2_q <= mp[19:0];
					dx_q <= -$signed({1'b0, k_q});
					dy_q <= -$signed({1'b0, k_q});
					state_q <= S_WIN;
				end
				S_WIN: begin
					d2_q <= 8'(dx_q) * 8'(dx_q) + 8'(dy_q) * 8'(dy_q);
					state_q <= S_WMUL;
				end
				S_WMUL: begin
					wprod_q <= mp[31:0];
					state_q <= S_WCMP;
				end
				S_WCMP: begin
					if (dy_q == $signed({1'b0, k_q})) begin
						dy_q <= -$signed({1'b0, k_q});
						if (dx_q == $signed({1'b0, k_q}))
							state_q <= S_IDLE;
						else begin
							dx_q <= dx_q + 1'b1;
							state_q <= S_WIN;
						end
					end else begin
						dy_q <= dy_q + 1'b1;
						state_q <= S_WIN;
					end
				end
				S_RD: state_q <= S_RD2;
				S_RD2: begin
					if (!rsp_v_q || rsp.ready) begin
						rsp_q.occupied  <= rd_q;
						rsp_q.cell_cost <= rd_q ? lsogi_pkg::COST_OCC : 7'd0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> state_q == S_IDLE)
		else $error("request taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_v_q && !rsp.ready |=> rsp_v_q && $stable(rsp_q))
		else $error("response dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		we && wdata |-> state_q == S_WCMP)
		else $error("grid mark outside window walk");
endmodule
`default_nettype wire
